// ===== hdl/cvu_pkg.sv =====
// Package: shared constants and types for the CORDIC vectoring unit.
`default_nettype none
package cvu_pkg;
   localparam int unsigned ITERATIONS_DEFAULT = 15;
   localparam int unsigned DATA_WIDTH_DEFAULT = 32;
   localparam int unsigned FIELD_WIDTH = 32;
   localparam int unsigned INDEX_WIDTH = 4;
   localparam int unsigned DIGIT_WIDTH = 1;

   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_COMPUTE     = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_OUTPUT
   } state_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic load;
      logic bit_step;
      logic iter_done;
   } ctrl_type;
endpackage
`default_nettype wire

// ===== hdl/cvu_datapath.sv =====
// Bit-serial datapath: x, y and z adders and the arithmetic shift taps.
`default_nettype none
module cvu_datapath
   import cvu_pkg::*;
#(
   parameter int unsigned ITERATIONS = ITERATIONS_DEFAULT,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT,
   localparam int unsigned IW = $clog2(ITERATIONS + 1),
   localparam int unsigned BW = $clog2(DATA_WIDTH)
) (
   input  wire logic                  clock,
   input  wire ctrl_type              ctrl,
   input  wire logic [IW-1:0]         iter,
   input  wire logic [BW-1:0]         bit_idx,
   input  wire logic [DATA_WIDTH-1:0] x_load,
   input  wire logic [DATA_WIDTH-1:0] y_load,
   input  wire logic [DATA_WIDTH-1:0] angle,
   output logic [DATA_WIDTH-1:0]      x_q,
   output logic [DATA_WIDTH-1:0]      y_q,
   output logic [DATA_WIDTH-1:0]      z_q
);
   // Working words rotate LSB first; a snapshot keeps the word of the
   // previous iteration so shifted bits can be tapped.
   logic [DATA_WIDTH-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [DATA_WIDTH-1:0] xs_ff, xs_in, ys_ff, ys_in, a_ff, a_in;
   logic                  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in, dir_ff, dir_in;
   logic                  xb, yb, ab, sub_y;
   logic [BW+IW-1:0]      tap;
   logic [BW-1:0]         tap_idx;
   logic [1:0]            sx, sy, sz;

   always_comb begin
      tap = {{IW{1'b0}}, bit_idx} + (BW+IW)'(iter);
      tap_idx = (tap >= (BW+IW)'(DATA_WIDTH)) ? BW'(DATA_WIDTH - 1) : tap[BW-1:0];
      xb = xs_ff[tap_idx];
      yb = ys_ff[tap_idx];
      ab = a_ff[0];
      sub_y = dir_ff;
      // y -/+ (x>>i), x +/- (y>>i), z +/- angle
      sy = {1'b0, y_ff[0]} + {1'b0, xb ^ sub_y} + {1'b0, cy_ff};
      sx = {1'b0, x_ff[0]} + {1'b0, yb ^ ~sub_y} + {1'b0, cx_ff};
      sz = {1'b0, z_ff[0]} + {1'b0, ab ^ ~sub_y} + {1'b0, cz_ff};
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      xs_in = xs_ff; ys_in = ys_ff; a_in = a_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; dir_in = dir_ff;
      if (ctrl.load) begin
         x_in = x_load; y_in = y_load; z_in = '0;
         xs_in = x_load; ys_in = y_load; a_in = angle;
         dir_in = ~y_load[DATA_WIDTH-1];
         cy_in = ~y_load[DATA_WIDTH-1];
         cx_in = y_load[DATA_WIDTH-1];
         cz_in = y_load[DATA_WIDTH-1];
      end else if (ctrl.bit_step) begin
         x_in = {sx[0], x_ff[DATA_WIDTH-1:1]};
         y_in = {sy[0], y_ff[DATA_WIDTH-1:1]};
         z_in = {sz[0], z_ff[DATA_WIDTH-1:1]};
         a_in = {a_ff[0], a_ff[DATA_WIDTH-1:1]};
         cx_in = sx[1]; cy_in = sy[1]; cz_in = sz[1];
         if (ctrl.iter_done) begin
            xs_in = {sx[0], x_ff[DATA_WIDTH-1:1]};
            ys_in = {sy[0], y_ff[DATA_WIDTH-1:1]};
            a_in = angle;
            dir_in = ~sy[0];
            // dir true means y non-negative: subtract x>>i from y
            cy_in = ~sy[0]; cx_in = sy[0]; cz_in = sy[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      xs_ff <= xs_in; ys_ff <= ys_in; a_ff <= a_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; dir_ff <= dir_in;
   end

   assign x_q = x_ff;
   assign y_q = y_ff;
   assign z_q = z_ff;
endmodule
`default_nettype wire

// ===== hdl/cordic_vectoring_unit.sv =====
// Top level: CORDIC vectoring unit with angle table and serial sequencer.
//
// Usage: items arrive on the req_ stream. operation 0 writes one angle
// table entry and gives no result; operation 1 starts a vectoring run
// on x_in/y_in. Each compute returns x, residual y and angle z on rsp_.
// The result is built one bit per cycle through the shared serial
// adders, and rsp_tvalid rises once the last bit of the last iteration
// has landed in the working registers.
// A compute holds the input from the accept cycle through the rotate
// iterations to the result transfer; a table write leaves the unit
// idle and ready for the next item. One item is in progress at a time;
// a new item is taken once the result has transferred.
// When the receiver stalls the result holds in rsp_tdata until taken.
// Reset clears the angle table to zero and drops rsp_tvalid.
// Writes to entries at or beyond ITERATIONS are ignored.
`default_nettype none
module cordic_vectoring_unit
   import cvu_pkg::*;
#(
   parameter int unsigned ITERATIONS = ITERATIONS_DEFAULT,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: x_in[31:0], y_in[63:32], table_index[67:64], table_value[99:68], pad
   input  wire logic [103:0] req_tdata,
   // tuser: operation
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: x_out[31:0], y_out[63:32], z_out[95:64]
   output logic [95:0]       rsp_tdata
);
   localparam int unsigned IW = $clog2(ITERATIONS + 1);
   localparam int unsigned BW = $clog2(DATA_WIDTH);

   state_type state_ff, state_in;
   logic [DATA_WIDTH-1:0] table_ff [ITERATIONS];
   logic [IW-1:0] iter_ff, iter_in;
   logic [BW-1:0] bit_ff, bit_in;
   ctrl_type      ctrl;
   logic          accept, last_bit, last_iter;
   logic [DATA_WIDTH-1:0] x_load, y_load, wr_val, angle, x_q, y_q, z_q;
   logic [IW-1:0] angle_idx;
   logic [INDEX_WIDTH-1:0] wr_idx;

   function automatic logic [DATA_WIDTH-1:0] fit(input logic [FIELD_WIDTH-1:0] f);
      logic [DATA_WIDTH+FIELD_WIDTH-1:0] e;
      e = {{DATA_WIDTH{f[FIELD_WIDTH-1]}}, f};
      return e[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] back(input logic [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH+31:0] e;
      e = {{32{v[DATA_WIDTH-1]}}, v};
      return e[31:0];
   endfunction

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign x_load = fit(req_tdata[31:0]);
   assign y_load = fit(req_tdata[63:32]);
   assign wr_idx = req_tdata[67:64];
   assign wr_val = fit(req_tdata[99:68]);
   assign last_bit = (bit_ff == BW'(DATA_WIDTH - 1));
   assign last_iter = (iter_ff == IW'(ITERATIONS - 1));
   assign angle_idx = (state_ff == ST_IDLE) ? '0 : iter_ff + IW'(1);
   assign angle = (angle_idx < IW'(ITERATIONS)) ? table_ff[angle_idx] : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept && req_tuser == OP_COMPUTE) state_in = ST_ROTATE;
         ST_ROTATE: if (last_bit && last_iter) state_in = ST_OUTPUT;
         ST_OUTPUT: if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.load = accept && req_tuser == OP_COMPUTE;
      ctrl.bit_step = (state_ff == ST_ROTATE);
      ctrl.iter_done = (state_ff == ST_ROTATE) && last_bit;
      bit_in = bit_ff; iter_in = iter_ff;
      if (ctrl.load) begin
         bit_in = '0; iter_in = '0;
      end else if (ctrl.bit_step) begin
         bit_in = last_bit ? '0 : bit_ff + BW'(1);
         if (last_bit) iter_in = iter_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < ITERATIONS; i++) table_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && req_tuser == OP_TABLE_WRITE && 32'(wr_idx) < ITERATIONS)
            table_ff[IW'(wr_idx)] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      iter_ff <= iter_in;
   end

   // The final bit lands on the edge into ST_OUTPUT and the datapath then
   // holds, so the result is read straight from the working registers.
   assign rsp_tdata = {back(z_q), back(y_q), back(x_q)};
   assign rsp_tvalid = (state_ff == ST_OUTPUT);

   cvu_datapath #(.ITERATIONS(ITERATIONS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock(clock), .ctrl(ctrl), .iter(iter_ff), .bit_idx(bit_ff),
      .x_load(x_load), .y_load(y_load), .angle(angle),
      .x_q(x_q), .y_q(y_q), .z_q(z_q)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> !req_tready) else $error("ready while busy");
   a_counters: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (bit_ff == '0 && iter_ff == '0)) else $error("counters");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule
`default_nettype wire

// ===== bench/cvu_checker.sv =====
// Checker: watches both streams of the CORDIC vectoring unit, predicts and compares results.
`default_nettype none
module cvu_checker
   import cvu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [103:0] req_tdata,
   input  wire logic         req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [95:0]  rsp_tdata,
   output int                pending_count,
   output int                error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_ROT = ITERATIONS_DEFAULT;

   typedef struct packed {
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } vector_result_type;

   logic [31:0]       angle_store [N_ROT];
   vector_result_type expected_vectors [$];

   initial error_count = 0;
   assign pending_count = expected_vectors.size();

   function automatic vector_result_type rotate_to_axis(logic signed [31:0] xi,
                                                        logic signed [31:0] yi);
      logic signed [31:0] x, y, z, xs, ys;
      vector_result_type r;
      x = xi;
      y = yi;
      z = '0;
      for (int i = 0; i < N_ROT; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (!y[31]) begin
            y = y - xs;
            x = x + ys;
            z = z + angle_store[i];
         end else begin
            y = y + xs;
            x = x - ys;
            z = z - angle_store[i];
         end
      end
      r.x = x;
      r.y = y;
      r.z = z;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      vector_result_type got, want;
      if (reset) begin
         foreach (angle_store[i]) angle_store[i] = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_COMPUTE) begin
               expected_vectors.push_back(rotate_to_axis(req_tdata[31:0], req_tdata[63:32]));
            end else if (req_tdata[67:64] < N_ROT) begin
               angle_store[req_tdata[67:64]] = req_tdata[99:68];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_vectors.size() == 0) begin
               report_mismatch("unexpected transfer", got.x, '0);
            end else begin
               want = expected_vectors.pop_front();
               if (got.x !== want.x) report_mismatch("x_out", got.x, want.x);
               if (got.y !== want.y) report_mismatch("y_out", got.y, want.y);
               if (got.z !== want.z) report_mismatch("z_out", got.z, want.z);
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== bench/tb_cordic_vectoring_unit.sv =====
// Testbench top: drives table writes and vectoring runs and gives the verdict.
`default_nettype none
module tb_cordic_vectoring_unit;
   import cvu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // watchdog counts cycles without any transfer
   localparam int IDLE_LIMIT   = 5000;
   localparam int N_RANDOM     = 1420;
   localparam int SETTLE       = 600;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;   // x_in, y_in, table_index, table_value, pad
   logic         req_tuser = OP_TABLE_WRITE;   // operation
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;        // x_out, y_out, z_out
   int           pending_count, error_count;
   bit           long_hold = 1'b0;
   bit           stimulus_done = 1'b0;
   int           quiet_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   cordic_vectoring_unit dut (.*);

   cvu_checker u_checker (.*);

   // one transfer on the request stream, with a random gap ahead of it
   task automatic send_item(input logic op, input logic [31:0] x, input logic [31:0] y,
                            input logic [3:0] idx, input logic [31:0] angle);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;   // runs of back-to-back offers
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, angle, idx, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] edgy_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         4: return $urandom_range(0, 4095) - 2048;
         default: return $urandom;
      endcase
   endfunction

   // receiver: random stall per result; the long hold-off runs inside the same loop
   initial begin
      int wait_cycles;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (2000) @(posedge clock);
            long_hold = 1'b0;
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
         if (wait_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // watchdog on cycles without a transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || long_hold)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: compute with empty table, table loads incl. ignored index 15
      send_item(OP_COMPUTE, 32'h4000_0000, 32'h4000_0000, 4'd0, 32'h0);
      for (int i = 0; i < 15; i++)
         send_item(OP_TABLE_WRITE, 32'h0, 32'h0, i[3:0], 32'h2000_0000 >> i);
      send_item(OP_TABLE_WRITE, $urandom, $urandom, 4'd15, 32'hdead_beef);
      send_item(OP_COMPUTE, 32'h7fff_ffff, 32'h7fff_ffff, 4'd15, 32'hffff_ffff);
      send_item(OP_COMPUTE, 32'h8000_0000, 32'h8000_0000, 4'd0, 32'h0);
      send_item(OP_COMPUTE, 32'h8000_0000, 32'h7fff_ffff, 4'd0, 32'h0);
      send_item(OP_COMPUTE, 32'h0, 32'hffff_ffff, 4'd0, 32'h0);
      send_item(OP_COMPUTE, 32'hffff_ffff, 32'h0, 4'd0, 32'h0);
      send_item(OP_TABLE_WRITE, 32'h0, 32'h0, 4'd14, 32'h8000_0000);
      send_item(OP_TABLE_WRITE, 32'h0, 32'h0, 4'd0, 32'h7fff_ffff);
      send_item(OP_COMPUTE, 32'h0000_0001, 32'h8000_0000, 4'd0, 32'h0);
      req_tvalid <= 1'b0;

      // pause until every result is back
      @(posedge clock);
      wait (pending_count == 0);

      // receiver holds off while the sender keeps offering
      long_hold = 1'b1;

      // random part: mostly computes, writes refresh the table
      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 4) == 0)
            send_item(OP_TABLE_WRITE, $urandom, $urandom,
                      4'($urandom_range(0, 15)), edgy_word());
         else
            send_item(OP_COMPUTE, edgy_word(), edgy_word(), 4'($urandom), $urandom);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      wait (pending_count == 0);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
